[hw/rtl/bbr_pkg.sv]
// ----------------------------------------------------------------------------
// bbr_pkg
// shared constants, register indexes and sequencer states of the band buffer
// line rasterizer
// ----------------------------------------------------------------------------
package bbr_pkg;

  localparam int BUFFER_BYTES = 65536;
  localparam int ROW_BYTES    = 640;
  localparam int ABITS        = $clog2(BUFFER_BYTES);
  localparam int CW           = 14;  // coordinate width after clamping
  localparam int PW           = 21;  // raw pixel address width

  // configuration register indexes
  localparam logic [2:0] REG_ORIGIN_X   = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y   = 3'd1;
  localparam logic [2:0] REG_LIMIT_X    = 3'd2;
  localparam logic [2:0] REG_LIMIT_Y    = 3'd3;
  localparam logic [2:0] REG_ODD_OFFSET = 3'd4;

  // command codes
  localparam logic CMD_DRAW = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_PIX,
    ST_RMW,
    ST_STEP,
    ST_RD,
    ST_RDW,
    ST_OUT
  } state_t;

endpackage

[hw/rtl/band_buffer_line_rasterizer.sv]
// ----------------------------------------------------------------------------
// band_buffer_line_rasterizer
// draws clamped lines into a bit-packed printer band buffer held in ram and
// serves single byte reads of that buffer
// ----------------------------------------------------------------------------
// a read passes ST_RD, ST_RDW and ST_OUT; a draw is paced by the per-pixel
//   read-modify-write on the single ram port pair (ST_PIX, ST_RMW, ST_STEP)
// throughput: one item at a time, the next is taken once the result is staged
// reset: rst_n low clears control state; afterwards a clearing pass writes
//   zero to all BUFFER_BYTES bytes, one per cycle, with no items taken
//   meanwhile (config writes are still taken)
module band_buffer_line_rasterizer
  import bbr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  // start_x[11:0] start_y[26:12] end_x[38:27] end_y[53:39] ink[54] solid[55]
  // read_address[71:56]
  input  logic [71:0] in_tdata,
  // command[0]
  input  logic        in_tuser,
  // results
  output logic        out_tvalid,
  input  logic        out_tready,
  // read_data[7:0] pixels_drawn[22:8], zero pad above
  output logic [23:0] out_tdata,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  state_t state_r, state_nxt;

  // configuration registers
  logic [9:0]  org_x_r, org_y_r, lim_x_r;
  logic [13:0] lim_y_r;
  logic [15:0] odd_off_r;

  // clearing pass counter
  logic [ABITS:0] clr_r;

  // command capture
  logic        ink_r, solid_r;
  logic [15:0] raddr_r;
  logic [CW-1:0] x1_r, y1_r, x2_r, y2_r;

  // dda walk state
  logic          xmaj_r, neg_r;
  logic [CW-1:0] maj_r, min0_r, dlt_r, dmin_r, q_r, rem_r, stp_r;
  logic [14:0]   drawn_r;

  // pixel in flight
  logic [ABITS-1:0] paddr_r;
  logic             pok_r;
  logic [7:0]       mask_r;

  // result staging
  logic [7:0]  res_data_r;
  logic [14:0] res_cnt_r;
  logic        out_valid_r;
  logic [7:0]  out_data_r;
  logic [14:0] out_cnt_r;

  // ram
  logic             ram_we;
  logic [ABITS-1:0] ram_waddr, ram_raddr;
  logic [7:0]       ram_wdata, ram_rdata;

  bbr_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // end clamping to the viewport: 0 up to limit minus origin
  function automatic logic [CW-1:0] clamp_x(logic [11:0] v, logic [9:0] org,
                                            logic [9:0] lim);
    logic signed [12:0] sum, t;
    begin
      sum = $signed({v[11], v}) + $signed({3'b0, org});
      if (sum > $signed({3'b0, lim})) t = $signed({3'b0, lim}) - $signed({3'b0, org});
      else t = $signed({v[11], v});
      if (t < 0) clamp_x = '0;
      else clamp_x = {4'b0, t[9:0]};
    end
  endfunction

  function automatic logic [CW-1:0] clamp_y(logic [14:0] v, logic [9:0] org,
                                            logic [13:0] lim);
    logic signed [15:0] sum, t;
    begin
      sum = $signed({v[14], v}) + $signed({6'b0, org});
      if (sum > $signed({2'b0, lim})) t = $signed({2'b0, lim}) - $signed({6'b0, org});
      else t = $signed({v[14], v});
      if (t < 0) clamp_y = '0;
      else clamp_y = t[13:0];
    end
  endfunction

  logic in_xfer, out_xfer;
  assign in_xfer  = in_tvalid && in_tready;
  assign out_xfer = out_valid_r && out_tready;
  assign cfg_ready = 1'b1;

  // setup: deltas and major axis choice
  logic signed [CW:0] ddx, ddy;
  logic [CW-1:0]      adx, ady;
  logic               xmaj_w, swap_w, single_w;
  logic [CW-1:0]      maj0_w, min0_w, min1_w, dlt_w;
  logic signed [CW:0] dmin_s;

  always_comb begin
    ddx = $signed({1'b0, x2_r}) - $signed({1'b0, x1_r});
    ddy = $signed({1'b0, y2_r}) - $signed({1'b0, y1_r});
    adx = ddx[CW] ? CW'(-ddx) : ddx[CW-1:0];
    ady = ddy[CW] ? CW'(-ddy) : ddy[CW-1:0];
    xmaj_w   = ady < adx;
    single_w = (x1_r == x2_r) && (y1_r == y2_r);
    // walk always goes from the end with the smaller major coordinate
    swap_w   = xmaj_w ? (x1_r > x2_r) : (y1_r > y2_r);
    if (xmaj_w) begin
      maj0_w = swap_w ? x2_r : x1_r;
      min0_w = swap_w ? y2_r : y1_r;
      min1_w = swap_w ? y1_r : y2_r;
      dlt_w  = adx;
    end else begin
      maj0_w = swap_w ? y2_r : y1_r;
      min0_w = swap_w ? x2_r : x1_r;
      min1_w = swap_w ? x1_r : x2_r;
      dlt_w  = ady;
    end
    dmin_s = $signed({1'b0, min1_w}) - $signed({1'b0, min0_w});
  end

  // current pixel and its byte address
  logic [CW-1:0] minor_w, cx, cy;
  logic [14:0]   abs_x, abs_y;
  logic [PW-1:0] pix_addr;
  logic          pix_ok;

  always_comb begin
    minor_w  = neg_r ? (min0_r - q_r) : (min0_r + q_r);
    cx       = xmaj_r ? maj_r : minor_w;
    cy       = xmaj_r ? minor_w : maj_r;
    abs_x    = {1'b0, cx} + {5'b0, org_x_r};
    abs_y    = {1'b0, cy} + {5'b0, org_y_r};
    pix_addr = (abs_y[0] ? {5'b0, odd_off_r} : '0)
             + PW'(abs_y[14:4]) * PW'(ROW_BYTES)
             + PW'(abs_x);
    pix_ok   = (solid_r || !stp_r[1])
            && (abs_x <= {5'b0, lim_x_r})
            && (abs_y <= {1'b0, lim_y_r})
            && (pix_addr < PW'(BUFFER_BYTES));
  end

  // dda remainder update: one compare and subtract per step
  logic [CW:0] rem_sum;
  logic        rem_wrap;
  assign rem_sum  = {1'b0, rem_r} + {1'b0, dmin_r};
  assign rem_wrap = rem_sum >= {1'b0, dlt_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_r == (ABITS+1)'(BUFFER_BYTES - 1)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_xfer) state_nxt = (in_tuser == CMD_READ) ? ST_RD : ST_SETUP;
      end
      ST_SETUP: state_nxt = single_w ? ST_OUT : ST_PIX;
      ST_PIX:   state_nxt = ST_RMW;
      ST_RMW:   state_nxt = ST_STEP;
      ST_STEP:  state_nxt = (stp_r == dlt_r) ? ST_OUT : ST_PIX;
      ST_RD:    state_nxt = ST_RDW;
      ST_RDW:   state_nxt = ST_OUT;
      ST_OUT:   if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_tready = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = paddr_r;
    ram_wdata = ink_r ? (ram_rdata | mask_r) : (ram_rdata & ~mask_r);
    ram_raddr = pix_addr[ABITS-1:0];
    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r[ABITS-1:0];
        ram_wdata = '0;
      end
      ST_IDLE: in_tready = 1'b1;
      ST_RMW:  ram_we = pok_r;
      ST_RD:   ram_raddr = raddr_r[ABITS-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      org_x_r     <= 10'd0;
      org_y_r     <= 10'd0;
      lim_x_r     <= 10'd639;
      lim_y_r     <= 14'd10000;
      odd_off_r   <= 16'd24960;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_r <= clr_r + 1'b1;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ORIGIN_X:   org_x_r   <= cfg_data[9:0];
          REG_ORIGIN_Y:   org_y_r   <= cfg_data[9:0];
          REG_LIMIT_X:    lim_x_r   <= cfg_data[9:0];
          REG_LIMIT_Y:    lim_y_r   <= cfg_data[13:0];
          REG_ODD_OFFSET: odd_off_r <= cfg_data;
          default: ;
        endcase
      end
      // result register: loaded when free or drained in the same cycle
      if (state_r == ST_OUT && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          x1_r       <= clamp_x(in_tdata[11:0], org_x_r, lim_x_r);
          y1_r       <= clamp_y(in_tdata[26:12], org_y_r, lim_y_r);
          x2_r       <= clamp_x(in_tdata[38:27], org_x_r, lim_x_r);
          y2_r       <= clamp_y(in_tdata[53:39], org_y_r, lim_y_r);
          ink_r      <= in_tdata[54];
          solid_r    <= in_tdata[55];
          raddr_r    <= in_tdata[71:56];
          res_data_r <= '0;
          res_cnt_r  <= '0;
        end
      end
      ST_SETUP: begin
        xmaj_r  <= xmaj_w;
        maj_r   <= maj0_w;
        min0_r  <= min0_w;
        dlt_r   <= dlt_w;
        dmin_r  <= dmin_s[CW] ? CW'(-dmin_s) : dmin_s[CW-1:0];
        neg_r   <= dmin_s[CW];
        q_r     <= '0;
        rem_r   <= '0;
        stp_r   <= '0;
        drawn_r <= '0;
      end
      ST_PIX: begin
        paddr_r <= pix_addr[ABITS-1:0];
        pok_r   <= pix_ok;
        mask_r  <= 8'h80 >> abs_y[3:1];
      end
      ST_RMW: begin
        if (pok_r) drawn_r <= drawn_r + 1'b1;
      end
      ST_STEP: begin
        if (stp_r == dlt_r) begin
          res_cnt_r <= drawn_r;
        end else begin
          stp_r <= stp_r + 1'b1;
          maj_r <= maj_r + 1'b1;
          if (rem_wrap) begin
            rem_r <= CW'(rem_sum - {1'b0, dlt_r});
            q_r   <= q_r + 1'b1;
          end else begin
            rem_r <= rem_sum[CW-1:0];
          end
        end
      end
      ST_RDW: begin
        if ({1'b0, raddr_r} < 17'(BUFFER_BYTES)) res_data_r <= ram_rdata;
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_data_r <= res_data_r;
          out_cnt_r  <= res_cnt_r;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_cnt_r, out_data_r};

  // no item is taken during the clearing pass
  a_no_take_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !in_tready)
    else $error("item taken during clearing pass");

  // buffer writes come only from the clearing pass or a pixel update
  a_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_CLEAR || state_r == ST_RMW))
    else $error("unexpected buffer write");

  // a new result appears only after the sequencer reached its result state
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_OUT)
    else $error("result without a finished item");

  // the walk never runs past the major delta
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PIX || state_r == ST_STEP) |-> (stp_r <= dlt_r && rem_r < dlt_r))
    else $error("dda walk out of range");

endmodule

[hw/rtl/bbr_ram.sv]
// ----------------------------------------------------------------------------
// bbr_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module bbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
